### rtl/svpwm_single_shunt_duty_defines.svh
// assertion macros for the single shunt svpwm duty block
`ifndef SVPWM_SINGLE_SHUNT_DUTY_DEFINES_SVH
`define SVPWM_SINGLE_SHUNT_DUTY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SVSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svss assertion failed");

// next-cycle implication, checked outside reset
`define SVSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svss assertion failed");

`endif

### rtl/svss_pkg.sv
// shared types and constants of the single shunt svpwm duty block
package svss_pkg;

   localparam int unsigned VOLT_W = 16;
   localparam int unsigned CSR_W  = 15;

   localparam logic [CSR_W-1:0] PWM_PERIOD_RESET     = 15'd32767;
   localparam logic [CSR_W-1:0] MIN_WINDOW_RESET     = 15'd420;
   localparam logic [CSR_W-1:0] TRIGGER_OFFSET_RESET = 15'd0;

   typedef enum logic [1:0] {
      CSR_PWM_PERIOD     = 2'd0,
      CSR_MIN_WINDOW     = 2'd1,
      CSR_TRIGGER_OFFSET = 2'd2,
      CSR_SWAP_PHASES    = 2'd3
   } csr_index_type;

   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;
   localparam logic [2:0] SECTOR_6 = 3'd6;

   // sector and scaled active vector times
   typedef struct packed {
      logic [2:0]               sector;
      logic signed [VOLT_W-1:0] t1;
      logic signed [VOLT_W-1:0] t2;
   } active_type;

   // stretch flags carried from up-count to down-count
   typedef struct packed {
      logic first;
      logic second;
   } stretch_type;

endpackage

### rtl/svss_sector.sv
// sector decode, active vector pick and period scaling
module svss_sector (
   input  logic signed [svss_pkg::VOLT_W-1:0] vr1,
   input  logic signed [svss_pkg::VOLT_W-1:0] vr2,
   input  logic signed [svss_pkg::VOLT_W-1:0] vr3,
   input  logic [svss_pkg::CSR_W-1:0]         pwm_period,
   output svss_pkg::active_type               active
);
   import svss_pkg::*;

   logic [2:0]                 sector;
   logic signed [VOLT_W-1:0]   raw_t1;
   logic signed [VOLT_W-1:0]   raw_t2;
   logic signed [VOLT_W-1:0]   period_s;
   logic signed [2*VOLT_W-1:0] prod_t1;
   logic signed [2*VOLT_W-1:0] prod_t2;

   always_comb begin
      if (!vr1[VOLT_W-1]) begin
         if (!vr2[VOLT_W-1]) begin
            sector = SECTOR_3; raw_t2 = vr2; raw_t1 = vr1;
         end else if (!vr3[VOLT_W-1]) begin
            sector = SECTOR_5; raw_t2 = vr1; raw_t1 = vr3;
         end else begin
            sector = SECTOR_1; raw_t2 = -vr2; raw_t1 = -vr3;
         end
      end else begin
         if (!vr2[VOLT_W-1]) begin
            if (!vr3[VOLT_W-1]) begin
               sector = SECTOR_6; raw_t2 = vr3; raw_t1 = vr2;
            end else begin
               sector = SECTOR_2; raw_t2 = -vr3; raw_t1 = -vr1;
            end
         end else begin
            sector = SECTOR_4; raw_t2 = -vr1; raw_t1 = -vr2;
         end
      end
   end

   // q15 scaling: floor shift by 15, then keep 16 bits
   assign period_s = $signed({1'b0, pwm_period});
   assign prod_t1  = period_s * raw_t1;
   assign prod_t2  = period_s * raw_t2;

   assign active.sector = sector;
   assign active.t1     = prod_t1[2*VOLT_W-2:VOLT_W-1];
   assign active.t2     = prod_t2[2*VOLT_W-2:VOLT_W-1];

endmodule

### rtl/svss_compare.sv
// compare times, min window stretch, phase routing and adc triggers
module svss_compare (
   input  svss_pkg::active_type               active,
   input  logic                               count_up,
   input  logic [svss_pkg::CSR_W-1:0]         pwm_period,
   input  logic [svss_pkg::CSR_W-1:0]         min_window,
   input  logic [svss_pkg::CSR_W-1:0]         trigger_offset,
   input  logic                               swap_phases,
   input  svss_pkg::stretch_type              stretch,
   output svss_pkg::stretch_type              stretch_next,
   output logic signed [svss_pkg::VOLT_W-1:0] duty_a,
   output logic signed [svss_pkg::VOLT_W-1:0] duty_b,
   output logic signed [svss_pkg::VOLT_W-1:0] duty_c,
   output logic signed [svss_pkg::VOLT_W-1:0] trigger_first,
   output logic signed [svss_pkg::VOLT_W-1:0] trigger_second
);
   import svss_pkg::*;

   logic signed [VOLT_W-1:0] mw;
   logic signed [VOLT_W-1:0] off;
   logic signed [VOLT_W-1:0] diff;
   logic signed [VOLT_W-1:0] tc;
   logic signed [VOLT_W-1:0] tb;
   logic signed [VOLT_W-1:0] ta;
   logic signed [VOLT_W-1:0] add1;
   logic signed [VOLT_W-1:0] add2;
   logic signed [VOLT_W-1:0] dx;
   logic signed [VOLT_W-1:0] dy;
   logic signed [VOLT_W-1:0] sum_f;
   logic signed [VOLT_W-1:0] sum_s;
   logic signed [VOLT_W-1:0] quo_f;
   logic signed [VOLT_W-1:0] quo_s;
   logic                     short1;
   logic                     short2;

   assign mw   = $signed({1'b0, min_window});
   assign off  = $signed({1'b0, trigger_offset});
   assign diff = $signed({1'b0, pwm_period}) - active.t1 - active.t2;
   assign tc   = diff >>> 1;

   assign short1 = !(active.t1 > mw);
   assign short2 = !(active.t2 > mw);

   always_comb begin
      if (count_up) begin
         add1 = short1 ? mw : active.t1;
         add2 = short2 ? mw : active.t2;
         stretch_next.first  = stretch.first  | short1;
         stretch_next.second = stretch.second | short2;
      end else begin
         // give back the excess added on the up-count
         add1 = stretch.first  ? (active.t1 + active.t1 - mw) : active.t1;
         add2 = stretch.second ? (active.t2 + active.t2 - mw) : active.t2;
         stretch_next.first  = 1'b0;
         stretch_next.second = 1'b0;
      end
   end

   assign tb = tc + add1;
   assign ta = tb + add2;

   always_comb begin
      case (active.sector)
         SECTOR_3: begin duty_a = ta; dx = tb; dy = tc; end
         SECTOR_5: begin duty_a = tc; dx = ta; dy = tb; end
         SECTOR_1: begin duty_a = tb; dx = ta; dy = tc; end
         SECTOR_6: begin duty_a = tb; dx = tc; dy = ta; end
         SECTOR_2: begin duty_a = ta; dx = tc; dy = tb; end
         default:  begin duty_a = tc; dx = tb; dy = ta; end
      endcase
   end

   assign duty_b = swap_phases ? dx : dy;
   assign duty_c = swap_phases ? dy : dx;

   // divide by 4 toward zero: bump a negative floor quotient when bits drop
   assign sum_f = tb + tc;
   assign sum_s = ta + tb;
   assign quo_f = (sum_f >>> 2) + $signed({{(VOLT_W-1){1'b0}},
                  (sum_f[VOLT_W-1] & (|sum_f[1:0]))});
   assign quo_s = (sum_s >>> 2) + $signed({{(VOLT_W-1){1'b0}},
                  (sum_s[VOLT_W-1] & (|sum_s[1:0]))});

   assign trigger_first  = count_up ? (quo_f + off) : '0;
   assign trigger_second = count_up ? (quo_s + off) : '0;

endmodule

### rtl/svpwm_single_shunt_duty.sv
// top level of the single shunt space vector pwm duty block
// Takes one word per cycle while results are drained: three q15 reference
// voltages and the timer direction, and returns one word with the three
// phase compare values, the sector and, on up-count, two adc trigger
// points. An accepted word is held in an input register; the sector decode,
// the two 16x16 period scaling multipliers and the compare adder chain sit
// between that register and the result register, so rsp_valid rises when a
// word moves from the input register into the result register, and a new
// word can be taken every cycle as long as results are drained. If the
// result is not taken, the input register keeps one more word before
// req_ready drops. The min window stretch flags update when a word moves into
// the result register, so down-count words see the flags of the preceding
// up-count words in acceptance order. Configuration writes take effect at
// once and are expected only while the block is idle.
module svpwm_single_shunt_duty (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [svss_pkg::VOLT_W-1:0] req_vr1,
   input  logic signed [svss_pkg::VOLT_W-1:0] req_vr2,
   input  logic signed [svss_pkg::VOLT_W-1:0] req_vr3,
   input  logic                               req_count_up,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [svss_pkg::VOLT_W-1:0] rsp_duty_a,
   output logic signed [svss_pkg::VOLT_W-1:0] rsp_duty_b,
   output logic signed [svss_pkg::VOLT_W-1:0] rsp_duty_c,
   output logic [2:0]                         rsp_sector,
   output logic signed [svss_pkg::VOLT_W-1:0] rsp_trigger_first,
   output logic signed [svss_pkg::VOLT_W-1:0] rsp_trigger_second,
   output logic                               rsp_triggers_updated,
   // register write port
   input  logic                               csr_wr_en,
   input  svss_pkg::csr_index_type            csr_index,
   input  logic [svss_pkg::CSR_W-1:0]         csr_wdata
);
   import svss_pkg::*;

`include "svpwm_single_shunt_duty_defines.svh"

   // configuration registers
   logic [CSR_W-1:0] pwm_period_ff, pwm_period_in;
   logic [CSR_W-1:0] min_window_ff, min_window_in;
   logic [CSR_W-1:0] trigger_offset_ff, trigger_offset_in;
   logic             swap_phases_ff, swap_phases_in;

   // input stage
   logic                     s1_vld_ff, s1_vld_in;
   logic signed [VOLT_W-1:0] s1_vr1_ff, s1_vr2_ff, s1_vr3_ff;
   logic                     s1_up_ff;
   logic                     s1_load;
   logic                     s1_adv;

   // stretch flags
   stretch_type stretch_ff, stretch_in;
   stretch_type stretch_next;

   // result stage
   logic                     out_vld_ff, out_vld_in;
   logic signed [VOLT_W-1:0] out_duty_a_ff, out_duty_b_ff, out_duty_c_ff;
   logic [2:0]               out_sector_ff;
   logic signed [VOLT_W-1:0] out_trig_f_ff, out_trig_s_ff;
   logic                     out_trig_upd_ff;

   // compute results
   active_type               active;
   logic signed [VOLT_W-1:0] duty_a, duty_b, duty_c;
   logic signed [VOLT_W-1:0] trig_f, trig_s;

   // register writes
   always_comb begin
      pwm_period_in     = pwm_period_ff;
      min_window_in     = min_window_ff;
      trigger_offset_in = trigger_offset_ff;
      swap_phases_in    = swap_phases_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PWM_PERIOD:     pwm_period_in     = csr_wdata;
            CSR_MIN_WINDOW:     min_window_in     = csr_wdata;
            CSR_TRIGGER_OFFSET: trigger_offset_in = csr_wdata;
            CSR_SWAP_PHASES:    swap_phases_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff     <= PWM_PERIOD_RESET;
         min_window_ff     <= MIN_WINDOW_RESET;
         trigger_offset_ff <= TRIGGER_OFFSET_RESET;
         swap_phases_ff    <= 1'b0;
      end else begin
         pwm_period_ff     <= pwm_period_in;
         min_window_ff     <= min_window_in;
         trigger_offset_ff <= trigger_offset_in;
         swap_phases_ff    <= swap_phases_in;
      end
   end

   // pipeline flow: stage 1 moves on when the result register is free or drains
   assign s1_adv    = s1_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign s1_load   = req_valid && req_ready;

   assign s1_vld_in  = s1_load || (s1_vld_ff && !s1_adv);
   assign out_vld_in = s1_adv || (out_vld_ff && !rsp_ready);
   // flags only change when a word leaves stage 1
   assign stretch_in = s1_adv ? stretch_next : stretch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         stretch_ff <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         stretch_ff <= stretch_in;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_vr1_ff <= req_vr1;
         s1_vr2_ff <= req_vr2;
         s1_vr3_ff <= req_vr3;
         s1_up_ff  <= req_count_up;
      end
   end

   svss_sector u_sector (
      .vr1        (s1_vr1_ff),
      .vr2        (s1_vr2_ff),
      .vr3        (s1_vr3_ff),
      .pwm_period (pwm_period_ff),
      .active     (active)
   );

   svss_compare u_compare (
      .active         (active),
      .count_up       (s1_up_ff),
      .pwm_period     (pwm_period_ff),
      .min_window     (min_window_ff),
      .trigger_offset (trigger_offset_ff),
      .swap_phases    (swap_phases_ff),
      .stretch        (stretch_ff),
      .stretch_next   (stretch_next),
      .duty_a         (duty_a),
      .duty_b         (duty_b),
      .duty_c         (duty_c),
      .trigger_first  (trig_f),
      .trigger_second (trig_s)
   );

   // result word register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_duty_a_ff   <= duty_a;
         out_duty_b_ff   <= duty_b;
         out_duty_c_ff   <= duty_c;
         out_sector_ff   <= active.sector;
         out_trig_f_ff   <= trig_f;
         out_trig_s_ff   <= trig_s;
         out_trig_upd_ff <= s1_up_ff;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_duty_a           = out_duty_a_ff;
   assign rsp_duty_b           = out_duty_b_ff;
   assign rsp_duty_c           = out_duty_c_ff;
   assign rsp_sector           = out_sector_ff;
   assign rsp_trigger_first    = out_trig_f_ff;
   assign rsp_trigger_second   = out_trig_s_ff;
   assign rsp_triggers_updated = out_trig_upd_ff;

   // input side stalls only when both stages are full and the output is held
   `SVSS_ASSERT_NOW(a_ready_stall, clock, reset, !req_ready,
      s1_vld_ff && out_vld_ff && !rsp_ready)
   // a down-count word leaving stage 1 clears both stretch flags
   `SVSS_ASSERT_NEXT(a_down_clears, clock, reset, s1_adv && !s1_up_ff,
      stretch_ff == '0)
   // sector of a shown word is always one of the six
   `SVSS_ASSERT_NOW(a_sector_range, clock, reset, out_vld_ff,
      out_sector_ff >= SECTOR_1 && out_sector_ff <= SECTOR_6)
   // down-count words carry zero trigger points
   `SVSS_ASSERT_NOW(a_trig_zero, clock, reset, out_vld_ff && !out_trig_upd_ff,
      out_trig_f_ff == '0 && out_trig_s_ff == '0)

endmodule
